[src/pidm_pkg.sv]
package pidm_pkg;

  typedef enum logic [2:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_DRIVE_UPPER = 3'd3,
    REG_DRIVE_LOWER = 3'd4,
    REG_DEADZONE    = 3'd5,
    REG_INTEG_UPPER = 3'd6,
    REG_INTEG_LOWER = 3'd7
  } cfg_reg_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [15:0]        PROP_GAIN_RST   = 16'd1024;
  localparam logic [15:0]        INTEG_GAIN_RST  = 16'd38;
  localparam logic [15:0]        DERIV_GAIN_RST  = 16'd1280;
  localparam logic signed [15:0] DRIVE_UPPER_RST = 16'sd25600;
  localparam logic signed [15:0] DRIVE_LOWER_RST = -16'sd25600;
  localparam logic [14:0]        DEADZONE_RST    = 15'd1024;
  localparam logic signed [31:0] INTEG_UPPER_RST = 32'sd102400;
  localparam logic signed [31:0] INTEG_LOWER_RST = -32'sd102400;

endpackage

[src/pidm_if.sv]
interface pidm_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint;
  logic signed [15:0] measured;

  modport source (output valid, output setpoint, output measured, input ready);
  modport sink (input valid, input setpoint, input measured, output ready);
endinterface

interface pidm_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;
  logic               saturated;

  modport source (output valid, output drive, output saturated, input ready);
  modport sink (input valid, input drive, input saturated, output ready);
endinterface

[src/pid_derivative_on_measurement.sv]
// path: a result passes through the input, stage-a and output registers after its input transaction is accepted
// throughput: one transaction per cycle while result.ready is high, set by the error-sum update loop in stage a
// three register stages (input, integrator/difference, output) advance whenever
// the next stage is empty or draining, so the block never stalls on its own
// reset: synchronous active-high rst empties the pipeline, zeroes the error sum and
// last measurement, and loads the default gains and limits
module pid_derivative_on_measurement (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pidm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pidm_pkg::CFG_DATA_W-1:0]   cfg_data,
  pidm_sample_if.sink                       sample,
  pidm_result_if.source                     result
);

  // configuration
  logic [15:0]        prop_gain;
  logic [15:0]        integ_gain;
  logic [15:0]        deriv_gain;
  logic signed [15:0] drive_upper;
  logic signed [15:0] drive_lower;
  logic [14:0]        deadzone_offset;
  logic signed [31:0] integ_upper;
  logic signed [31:0] integ_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= pidm_pkg::PROP_GAIN_RST;
      integ_gain      <= pidm_pkg::INTEG_GAIN_RST;
      deriv_gain      <= pidm_pkg::DERIV_GAIN_RST;
      drive_upper     <= pidm_pkg::DRIVE_UPPER_RST;
      drive_lower     <= pidm_pkg::DRIVE_LOWER_RST;
      deadzone_offset <= pidm_pkg::DEADZONE_RST;
      integ_upper     <= pidm_pkg::INTEG_UPPER_RST;
      integ_lower     <= pidm_pkg::INTEG_LOWER_RST;
    end else if (cfg_we) begin
      case (pidm_pkg::cfg_reg_t'(cfg_index))
        pidm_pkg::REG_PROP_GAIN:   prop_gain       <= cfg_data[15:0];
        pidm_pkg::REG_INTEG_GAIN:  integ_gain      <= cfg_data[15:0];
        pidm_pkg::REG_DERIV_GAIN:  deriv_gain      <= cfg_data[15:0];
        pidm_pkg::REG_DRIVE_UPPER: drive_upper     <= cfg_data[15:0];
        pidm_pkg::REG_DRIVE_LOWER: drive_lower     <= cfg_data[15:0];
        pidm_pkg::REG_DEADZONE:    deadzone_offset <= cfg_data[14:0];
        pidm_pkg::REG_INTEG_UPPER: integ_upper     <= cfg_data[31:0];
        pidm_pkg::REG_INTEG_LOWER: integ_lower     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_valid;
  logic mid_valid;
  logic out_valid;
  logic out_take;
  logic mid_move;
  logic in_move;

  assign out_take     = out_valid & result.ready;
  assign mid_move     = mid_valid & (~out_valid | out_take);
  assign in_move      = in_valid & (~mid_valid | mid_move);
  assign sample.ready = ~in_valid | in_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (sample.ready) begin
        in_valid <= sample.valid;
      end
      if (in_move) begin
        mid_valid <= 1'b1;
      end else if (mid_move) begin
        mid_valid <= 1'b0;
      end
      if (mid_move) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // input register
  logic signed [15:0] sp_q;
  logic signed [15:0] meas_q;

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      sp_q   <= sample.setpoint;
      meas_q <= sample.measured;
    end
  end

  // stage a: error, measurement change, clamped error sum (cleared while the integral gain is zero)
  logic signed [15:0] last_measured;
  logic signed [31:0] error_sum;
  logic signed [31:0] error_sum_next;
  logic signed [16:0] err_a;
  logic signed [16:0] delta_a;
  logic signed [32:0] acc_a;
  logic signed [32:0] int_up_x;
  logic signed [32:0] int_lo_x;

  assign err_a    = {sp_q[15], sp_q} - {meas_q[15], meas_q};
  assign delta_a  = {meas_q[15], meas_q} - {last_measured[15], last_measured};
  assign acc_a    = {error_sum[31], error_sum} + {{16{err_a[16]}}, err_a};
  assign int_up_x = {integ_upper[31], integ_upper};
  assign int_lo_x = {integ_lower[31], integ_lower};

  always_comb begin
    if (integ_gain == 16'd0) begin
      error_sum_next = '0;
    end else if (acc_a > int_up_x) begin
      error_sum_next = integ_upper;
    end else if (acc_a < int_lo_x) begin
      error_sum_next = integ_lower;
    end else begin
      error_sum_next = acc_a[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_measured <= '0;
      error_sum     <= '0;
    end else if (in_move) begin
      last_measured <= meas_q;
      error_sum     <= error_sum_next;
    end
  end

  logic signed [16:0] err_b;
  logic signed [16:0] delta_b;
  logic signed [31:0] esum_b;

  always_ff @(posedge clk) begin
    if (in_move) begin
      err_b   <= err_a;
      delta_b <= delta_a;
      esum_b  <= error_sum_next;
    end
  end

  // stage b: products, dead zone, output clamp
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [33:0] p_prod;
  logic signed [48:0] i_prod;
  logic signed [33:0] d_prod;
  logic signed [25:0] p_term;
  logic signed [40:0] i_term;
  logic signed [25:0] d_term;
  logic signed [41:0] raw_b;
  logic signed [42:0] dz_b;
  logic signed [42:0] dz_ext;
  logic signed [42:0] up_x;
  logic signed [42:0] lo_x;
  logic signed [15:0] drive_next;
  logic               sat_next;

  assign kp_s   = {1'b0, prop_gain};
  assign ki_s   = {1'b0, integ_gain};
  assign kd_s   = {1'b0, deriv_gain};
  assign p_prod = kp_s * err_b;
  assign i_prod = ki_s * esum_b;
  assign d_prod = kd_s * delta_b;
  // dropping low bits of a two's complement value rounds toward minus infinity
  assign p_term = p_prod[33:8];
  assign i_term = i_prod[48:8];
  assign d_term = d_prod[33:8];
  assign raw_b  = {{16{p_term[25]}}, p_term} + {i_term[40], i_term}
                - {{16{d_term[25]}}, d_term};
  assign dz_ext = {28'd0, deadzone_offset};
  assign up_x   = {{27{drive_upper[15]}}, drive_upper};
  assign lo_x   = {{27{drive_lower[15]}}, drive_lower};

  always_comb begin
    if (raw_b > 42'sd0) begin
      dz_b = {raw_b[41], raw_b} + dz_ext;
    end else if (raw_b < 42'sd0) begin
      dz_b = {raw_b[41], raw_b} - dz_ext;
    end else begin
      dz_b = '0;
    end
    if (dz_b > up_x) begin
      drive_next = drive_upper;
      sat_next   = 1'b1;
    end else if (dz_b < lo_x) begin
      drive_next = drive_lower;
      sat_next   = 1'b1;
    end else begin
      drive_next = dz_b[15:0];
      sat_next   = 1'b0;
    end
  end

  // output register
  logic signed [15:0] drive_q;
  logic               sat_q;

  always_ff @(posedge clk) begin
    if (mid_move) begin
      drive_q <= drive_next;
      sat_q   <= sat_next;
    end
  end

  assign result.valid     = out_valid;
  assign result.drive     = drive_q;
  assign result.saturated = sat_q;

  // checks
  a_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    in_move && integ_gain == 16'd0 |=> error_sum == 32'sd0)
    else $error("error sum not cleared with zero integral gain");

  a_sum_in_range: assert property (@(posedge clk) disable iff (rst)
    in_move && integ_gain != 16'd0 && integ_lower <= integ_upper
    |=> error_sum <= $past(integ_upper) && error_sum >= $past(integ_lower))
    else $error("error sum outside its limits");

  a_last_meas: assert property (@(posedge clk) disable iff (rst)
    in_move |=> last_measured == $past(meas_q))
    else $error("last measurement not captured");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    mid_move |=> !result.saturated || result.drive == $past(drive_upper)
      || result.drive == $past(drive_lower))
    else $error("saturated drive not at a limit");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    mid_valid && out_valid && !result.ready |=> mid_valid)
    else $error("stage dropped while output stalled");

endmodule
